// ===== src/btt_pkg.sv =====
// Shared types, constants and sizes of the bucketed transposition table.
package btt_pkg;

  // The bucket count is a power of two, so the bucket index is the low hash bits.
  localparam int NUM_BUCKETS = 1024;
  localparam int WAYS        = 4;

  localparam int BUCKET_BITS = $clog2(NUM_BUCKETS);
  localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ADDR_BITS   = BUCKET_BITS + WAY_BITS;
  localparam int PRI_BITS    = 11;

  localparam logic [WAY_BITS-1:0] LAST_WAY = WAY_BITS'(WAYS - 1);

  localparam logic signed [16:0] SCORE_CLAMP_POS = 17'sd32000;
  localparam logic signed [16:0] SCORE_CLAMP_NEG = -17'sd32000;
  localparam logic signed [PRI_BITS-1:0] PRI_MAX = 11'sd1023;
  localparam logic [14:0] MATE_BOUND_RESET = 15'd31000;

  localparam logic KIND_PROBE = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  localparam logic [1:0] FLAG_EXACT = 2'd0;
  localparam logic [1:0] FLAG_LOWER = 2'd1;
  localparam logic [1:0] FLAG_UPPER = 2'd2;

  localparam logic [1:0] REG_SEARCH_AGE = 2'd0;
  localparam logic [1:0] REG_MATE_BOUND = 2'd1;

  typedef struct packed {
    logic               kind;
    logic [63:0]        hash;
    logic [6:0]         depth;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [7:0]         ply;
    logic signed [15:0] score;
    logic [15:0]        best_move;
  } btt_in_t;

  typedef struct packed {
    logic               found;
    logic               cutoff;
    logic signed [15:0] result_score;
    logic signed [15:0] new_alpha;
    logic signed [15:0] new_beta;
    logic [15:0]        entry_move;
    logic [6:0]         entry_depth;
    logic [1:0]         entry_flag;
    logic [1:0]         way_used;
  } btt_out_t;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic               valid;
    logic [31:0]        tag;
    logic [5:0]         age;
    logic [1:0]         flag;
    logic [6:0]         depth;
    logic [15:0]        move;
    logic signed [15:0] score;
  } btt_entry_t;

endpackage

// ===== src/btt_ram.sv =====
// Entry memory of the table: one write port and one registered read port.
module btt_ram
  import btt_pkg::*;
(
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  btt_entry_t           wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output btt_entry_t           rdata_r
);

  btt_entry_t mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== src/bucketed_transposition_table_unit.sv =====
// Top level of the bucketed transposition table: sequencer, way scan and result logic.
//
//   channel  | ports                              | handshake
//   ---------+------------------------------------+---------------------------------
//   input    | start, busy, in_item               | word taken when start && !busy
//   result   | out_valid, out_item                | word shown for one cycle only
//   config   | cfg_we, cfg_index, cfg_wdata       | register written when cfg_we
//
// A probe reads and then compares one way at a time (states S_RD, S_EV) until a hit or the
// last way; a hit then passes S_ADJ for score adjustment and S_FIN for the result, a miss goes
// to S_FIN directly. A store scans up to all WAYS ways the same way, then adjusts and writes.
// The single entry memory and the one shared way comparator handle one way at a time.
// After reset a clearing pass writes every entry invalid, all NUM_BUCKETS*2**WAY_BITS of them
// (4096 here), with busy high. The receiver cannot stall; out_valid lasts one cycle.
module bucketed_transposition_table_unit
  import btt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  btt_in_t     in_item,
  output logic        out_valid,
  output btt_out_t    out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata
);

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_RD   = 6'b000100,
    S_EV   = 6'b001000,
    S_ADJ  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [ADDR_BITS-1:0]        clr_cnt_r, clr_cnt_nxt;
  btt_in_t                     req_r, req_nxt;
  logic [WAY_BITS-1:0]         way_r, way_nxt;
  logic [WAY_BITS-1:0]         pick_r, pick_nxt;
  logic signed [PRI_BITS-1:0]  worst_r, worst_nxt;
  logic                        hit_r, hit_nxt;
  btt_entry_t                  match_r, match_nxt;
  logic signed [16:0]          adj_r, adj_nxt;
  logic                        out_valid_r, out_valid_nxt;
  btt_out_t                    out_r, out_nxt;
  logic [5:0]                  search_age_r;
  logic [14:0]                 mate_bound_r;

  logic                        ram_we;
  logic [ADDR_BITS-1:0]        ram_waddr;
  btt_entry_t                  ram_wdata;
  logic [ADDR_BITS-1:0]        ram_raddr;
  btt_entry_t                  ram_rdata;

  logic [BUCKET_BITS-1:0]      bucket;
  logic                        tag_hit;
  logic [5:0]                  age_dist;
  logic signed [PRI_BITS-1:0]  way_pri;
  logic signed [16:0]          adj_src;
  logic signed [16:0]          mb_pos;
  logic signed [16:0]          mb_neg;
  logic signed [16:0]          ply_ext;
  logic signed [16:0]          clamped;
  logic [1:0]                  store_flag;
  logic signed [15:0]          na;
  logic signed [15:0]          nb;
  logic                        cut;
  logic [WAY_BITS+1:0]         pick_wide;
  logic [WAY_BITS+1:0]         way_wide;

  btt_ram u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign bucket    = req_r.hash[BUCKET_BITS-1:0];
  assign ram_raddr = {bucket, way_r};
  assign tag_hit   = ram_rdata.valid && (ram_rdata.tag == req_r.hash[63:32]);

  // Replacement priority: deeper and more recent entries are kept.
  assign age_dist  = search_age_r - ram_rdata.age;
  assign way_pri   = $signed({2'b00, ram_rdata.depth, 2'b00})
                   - $signed({2'b00, age_dist, 3'b000});

  assign mb_pos    = $signed({2'b00, mate_bound_r});
  assign mb_neg    = -mb_pos;
  assign ply_ext   = $signed({9'b0, req_r.ply});
  assign adj_src   = (req_r.kind == KIND_STORE) ? 17'(req_r.score) : 17'(match_r.score);

  assign clamped   = (adj_r > SCORE_CLAMP_POS) ? SCORE_CLAMP_POS :
                     (adj_r < SCORE_CLAMP_NEG) ? SCORE_CLAMP_NEG : adj_r;

  assign pick_wide = {2'b00, pick_r};
  assign way_wide  = {2'b00, way_r};

  always_comb begin
    if (req_r.score <= req_r.alpha) begin
      store_flag = FLAG_UPPER;
    end else if (req_r.score >= req_r.beta) begin
      store_flag = FLAG_LOWER;
    end else begin
      store_flag = FLAG_EXACT;
    end
  end

  // Window tightening for a probe hit, from the adjusted stored score.
  always_comb begin
    na  = req_r.alpha;
    nb  = req_r.beta;
    cut = 1'b0;
    if (match_r.depth >= req_r.depth) begin
      if (match_r.flag == FLAG_EXACT) begin
        cut = 1'b1;
      end else begin
        if (match_r.flag == FLAG_LOWER && $signed(adj_r[15:0]) > req_r.alpha) begin
          na = adj_r[15:0];
        end else if (match_r.flag == FLAG_UPPER && $signed(adj_r[15:0]) < req_r.beta) begin
          nb = adj_r[15:0];
        end
        cut = (na >= nb);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    req_nxt       = req_r;
    way_nxt       = way_r;
    pick_nxt      = pick_r;
    worst_nxt     = worst_r;
    hit_nxt       = hit_r;
    match_nxt     = match_r;
    adj_nxt       = adj_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = {bucket, pick_r};
    ram_wdata     = '0;

    unique case (state_r)
      S_CLR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_item;
          way_nxt   = '0;
          pick_nxt  = '0;
          worst_nxt = PRI_MAX;
          hit_nxt   = 1'b0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      S_EV: begin
        if (req_r.kind == KIND_PROBE) begin
          if (tag_hit) begin
            hit_nxt   = 1'b1;
            match_nxt = ram_rdata;
            state_nxt = S_ADJ;
          end else if (way_r == LAST_WAY) begin
            state_nxt = S_FIN;
          end else begin
            way_nxt   = way_r + 1'b1;
            state_nxt = S_RD;
          end
        end else begin
          if (!ram_rdata.valid || tag_hit) begin
            pick_nxt  = way_r;
            state_nxt = S_ADJ;
          end else begin
            if (way_pri < worst_r) begin
              worst_nxt = way_pri;
              pick_nxt  = way_r;
            end
            if (way_r == LAST_WAY) begin
              state_nxt = S_ADJ;
            end else begin
              way_nxt   = way_r + 1'b1;
              state_nxt = S_RD;
            end
          end
        end
      end
      S_ADJ: begin
        // Mate scores move by ply: away from zero on store, toward zero on probe.
        adj_nxt = adj_src;
        if (adj_src > mb_pos) begin
          adj_nxt = (req_r.kind == KIND_STORE) ? adj_src + ply_ext : adj_src - ply_ext;
        end else if (adj_src < mb_neg) begin
          adj_nxt = (req_r.kind == KIND_STORE) ? adj_src - ply_ext : adj_src + ply_ext;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        out_nxt       = '0;
        out_nxt.new_alpha = req_r.alpha;
        out_nxt.new_beta  = req_r.beta;
        if (req_r.kind == KIND_STORE) begin
          ram_we          = 1'b1;
          ram_wdata.valid = 1'b1;
          ram_wdata.tag   = req_r.hash[63:32];
          ram_wdata.age   = search_age_r;
          ram_wdata.flag  = store_flag;
          ram_wdata.depth = req_r.depth;
          ram_wdata.move  = req_r.best_move;
          ram_wdata.score = clamped[15:0];
          out_nxt.result_score = clamped[15:0];
          out_nxt.entry_move   = req_r.best_move;
          out_nxt.entry_depth  = req_r.depth;
          out_nxt.entry_flag   = store_flag;
          out_nxt.way_used     = pick_wide[1:0];
        end else if (hit_r) begin
          out_nxt.found        = 1'b1;
          out_nxt.cutoff       = cut;
          out_nxt.result_score = adj_r[15:0];
          out_nxt.new_alpha    = na;
          out_nxt.new_beta     = nb;
          out_nxt.entry_move   = match_r.move;
          out_nxt.entry_depth  = match_r.depth;
          out_nxt.entry_flag   = match_r.flag;
          out_nxt.way_used     = way_wide[1:0];
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      search_age_r <= '0;
      mate_bound_r <= MATE_BOUND_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SEARCH_AGE: search_age_r <= cfg_wdata[5:0];
          REG_MATE_BOUND: mate_bound_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    way_r   <= way_nxt;
    pick_r  <= pick_nxt;
    worst_r <= worst_nxt;
    hit_r   <= hit_nxt;
    match_r <= match_nxt;
    adj_r   <= adj_nxt;
    out_r   <= out_nxt;
  end

  a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_FIN))
    else $error("result word without a finishing step");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  a_no_cutoff_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.found) |-> !out_r.cutoff)
    else $error("cutoff reported without a hit");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("two result words back to back");

  a_write_only_when_allowed: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLR) || (state_r == S_FIN && req_r.kind == KIND_STORE))
    else $error("entry memory written outside clear pass or store");

endmodule
